@@ hdl/bcu_pkg.sv @@
package bcu_pkg;

  localparam int unsigned MAX_M = 67;
  localparam int unsigned M_W   = 7;
  localparam int unsigned R_W   = 64;
  localparam int unsigned CNT_W = 6;

  // divider operand selects
  localparam logic [1:0] SEL_GCD = 2'd0;   // a % b
  localparam logic [1:0] SEL_DQ  = 2'd1;   // d / g
  localparam logic [1:0] SEL_RQ  = 2'd2;   // r / g
  localparam logic [1:0] SEL_NQ  = 2'd3;   // numer / dq

  typedef struct packed {
    logic       load;
    logic       gcd_init;
    logic       div_start;
    logic [1:0] div_sel;
    logic       gcd_step;
    logic       save_dq;
    logic       save_rq;
    logic       save_nq;
    logic       mul_step;
    logic       set_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic b_zero;
    logic d_over;
    logic bad;
  } sts_t;

endpackage

@@ hdl/bcu_if.sv @@
interface bcu_req_if;
  logic                     valid;
  logic                     ready;
  logic [bcu_pkg::M_W-1:0]  set_size;
  logic [bcu_pkg::M_W-1:0]  pick_count;
  modport source (output valid, set_size, pick_count, input ready);
  modport sink (input valid, set_size, pick_count, output ready);
endinterface

interface bcu_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [bcu_pkg::R_W-1:0]  combinations;
  logic                     bad_request;
  modport source (output valid, combinations, bad_request, input ready);
  modport sink (input valid, combinations, bad_request, output ready);
endinterface

@@ hdl/binomial_coefficient_unit.sv @@
// Binomial coefficient unit: each request (set_size m, pick_count n) returns
// one response with combinations = C(m, n) as 64-bit unsigned, or
// bad_request = 1 and combinations = 0 when n > m or m > MAX_M (67).
// One request is worked on at a time; the next is taken once the previous
// response has been written to the output register, which may still be
// waiting for its consumer. All divisions share the single restoring
// divider: each of the n steps runs a Euclidean gcd of (r, d) with k
// remainder passes, then divides d/g, r/g and numer/dq. A bad request
// or n = 0 goes from S_CHECK straight to S_FIN without any division.
module binomial_coefficient_unit (
  input  logic         clk,
  input  logic         rst,
  bcu_req_if.sink      req,
  bcu_rsp_if.source    rsp
);

  bcu_pkg::cmd_t cmd;
  bcu_pkg::sts_t sts;

  // sequencer: walks the steps and the gcd loop
  bcu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // running product, gcd registers, shared divider, result register
  bcu_dp u_dp (
    .clk          (clk),
    .set_size     (req.set_size),
    .pick_count   (req.pick_count),
    .cmd          (cmd),
    .sts          (sts),
    .combinations (rsp.combinations),
    .bad_request  (rsp.bad_request),
    .rst          (rst)
  );

`ifndef SYNTHESIS
  // an error response never carries a count
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_request) |-> (rsp.combinations == '0))
    else $error("bad request with nonzero count");

  // a valid count is never zero
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.bad_request) |-> (rsp.combinations != '0))
    else $error("zero count on good request");

  // one request at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");
`endif

endmodule

@@ hdl/bcu_div.sv @@
module bcu_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bcu_pkg::R_W-1:0]  dividend,
  input  logic [bcu_pkg::R_W-1:0]  divisor,
  output logic                     done,
  output logic [bcu_pkg::R_W-1:0]  quotient,
  output logic [bcu_pkg::R_W-1:0]  remainder
);

  logic                      busy;
  logic [bcu_pkg::CNT_W-1:0] cnt;
  logic [bcu_pkg::R_W:0]     rem_sh;
  logic                      ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {remainder, quotient[bcu_pkg::R_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient <= {quotient[bcu_pkg::R_W-2:0], ge};
      if (ge) begin
        remainder <= rem_sh[bcu_pkg::R_W-1:0] - divisor;
      end else begin
        remainder <= rem_sh[bcu_pkg::R_W-1:0];
      end
    end
  end

endmodule

@@ hdl/bcu_dp.sv @@
module bcu_dp (
  input  logic                     clk,
  input  logic [bcu_pkg::M_W-1:0]  set_size,
  input  logic [bcu_pkg::M_W-1:0]  pick_count,
  input  bcu_pkg::cmd_t            cmd,
  output bcu_pkg::sts_t            sts,
  output logic [bcu_pkg::R_W-1:0]  combinations,
  output logic                     bad_request,
  input  logic                     rst
);

  logic [bcu_pkg::M_W-1:0]  m, n, numer, d;
  logic [bcu_pkg::R_W-1:0]  r, a, b, dq, rq;
  logic [bcu_pkg::M_W-1:0]  nq;
  logic [bcu_pkg::R_W-1:0]  dvd, dvs, quo, rem;
  logic                     done;

  always_comb begin
    case (cmd.div_sel)
      bcu_pkg::SEL_GCD: begin dvd = a; dvs = b; end
      bcu_pkg::SEL_DQ: begin dvd = {{(bcu_pkg::R_W-bcu_pkg::M_W){1'b0}}, d}; dvs = a; end
      bcu_pkg::SEL_RQ: begin dvd = r; dvs = a; end
      bcu_pkg::SEL_NQ: begin dvd = {{(bcu_pkg::R_W-bcu_pkg::M_W){1'b0}}, numer}; dvs = dq; end
      default: begin dvd = a; dvs = b; end
    endcase
  end

  bcu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign sts.div_done = done;
  assign sts.b_zero   = (b == '0);
  assign sts.d_over   = (d > n);
  assign sts.bad      = (n > m) || (m > bcu_pkg::M_W'(bcu_pkg::MAX_M));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m     <= set_size;
      n     <= pick_count;
      numer <= set_size;
      d     <= bcu_pkg::M_W'(1);
      r     <= bcu_pkg::R_W'(1);
    end
    if (cmd.gcd_init) begin
      a <= r;
      b <= {{(bcu_pkg::R_W-bcu_pkg::M_W){1'b0}}, d};
    end
    if (cmd.gcd_step) begin
      a <= b;
      b <= rem;
    end
    if (cmd.save_dq) dq <= quo;
    if (cmd.save_rq) rq <= quo;
    if (cmd.save_nq) nq <= quo[bcu_pkg::M_W-1:0];   // numer / dq fits numer's width
    if (cmd.mul_step) begin
      r     <= rq * {{(bcu_pkg::R_W-bcu_pkg::M_W){1'b0}}, nq};
      numer <= numer - 1'b1;
      d     <= d + 1'b1;
    end
    if (cmd.set_out) begin
      combinations <= sts.bad ? '0 : r;
      bad_request  <= sts.bad;
    end
  end

endmodule

@@ hdl/bcu_ctrl.sv @@
module bcu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  bcu_pkg::sts_t sts,
  output bcu_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_GINIT = 3'd2;
  localparam logic [2:0] S_GTEST = 3'd3;
  localparam logic [2:0] S_WGCD  = 3'd4;
  localparam logic [2:0] S_WDIV  = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] sel, sel_next;     // divide in flight during S_WGCD / S_WDIV
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cmd            = '0;
    cmd.div_sel    = sel;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad || sts.d_over) state_next = S_FIN;
        else state_next = S_GINIT;
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_next   = S_GTEST;
      end
      S_GTEST: begin
        cmd.div_start = 1'b1;
        if (sts.b_zero) begin
          cmd.div_sel = bcu_pkg::SEL_DQ;
          sel_next    = bcu_pkg::SEL_DQ;
          state_next  = S_WDIV;
        end else begin
          cmd.div_sel = bcu_pkg::SEL_GCD;
          sel_next    = bcu_pkg::SEL_GCD;
          state_next  = S_WGCD;
        end
      end
      S_WGCD: begin
        if (sts.div_done) begin
          cmd.gcd_step = 1'b1;
          state_next   = S_GTEST;
        end
      end
      S_WDIV: begin
        if (sts.div_done) begin
          case (sel)
            bcu_pkg::SEL_DQ: begin
              cmd.save_dq   = 1'b1;
              cmd.div_start = 1'b1;
              cmd.div_sel   = bcu_pkg::SEL_RQ;
              sel_next      = bcu_pkg::SEL_RQ;
            end
            bcu_pkg::SEL_RQ: begin
              cmd.save_rq   = 1'b1;
              cmd.div_start = 1'b1;
              cmd.div_sel   = bcu_pkg::SEL_NQ;
              sel_next      = bcu_pkg::SEL_NQ;
            end
            default: begin
              cmd.save_nq = 1'b1;
              state_next  = S_MUL;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = S_CHECK;
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.set_out    = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= bcu_pkg::SEL_GCD;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

@@ tb/binomial_coefficient_unit_tb.sv @@
`timescale 1ns / 100ps

module binomial_coefficient_unit_tb;

  typedef struct packed {
    logic [bcu_pkg::R_W-1:0] combinations;
    logic                    bad_request;
  } choose_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcu_req_if req_ch ();
  bcu_rsp_if rsp_ch ();

  binomial_coefficient_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pending predictions, oldest first.
  choose_result_t pending_choose[$];
  int             error_count = 0;

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.set_size   = '0;
    req_ch.pick_count = '0;
    rsp_ch.ready      = 1'b0;
  end

  // Predicted C(m, n), built step by step with the gcd reduction.
  function automatic choose_result_t predict_choose(logic [bcu_pkg::M_W-1:0] m,
                                                    logic [bcu_pkg::M_W-1:0] n);
    choose_result_t res;
    logic [bcu_pkg::R_W-1:0] r, numer, a, b, t, g, dq;
    res.combinations = '0;
    res.bad_request  = 1'b1;
    if (n > m || m > bcu_pkg::MAX_M) return res;
    r     = bcu_pkg::R_W'(1);
    numer = bcu_pkg::R_W'(m);
    for (int d = 1; d <= n; d++) begin
      a = r;
      b = bcu_pkg::R_W'(d);
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      g     = a;
      dq    = bcu_pkg::R_W'(d) / g;
      r     = r / g;
      r     = r * (numer / dq);
      numer = numer - 1'b1;
    end
    res.combinations = r;
    res.bad_request  = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [bcu_pkg::R_W-1:0] got,
                                 logic [bcu_pkg::R_W-1:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Send one request after a random gap; valid is held until accepted.
  // Valid is left high after the accepting edge until the next call or a
  // drain drops it, so valid changes once per falling edge.
  task automatic send_request(logic [bcu_pkg::M_W-1:0] m, logic [bcu_pkg::M_W-1:0] n);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.set_size   <= m;
    req_ch.pick_count <= n;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_choose.push_back(predict_choose(m, n));
    @(negedge clk);
  endtask

  // Receiver: random stall per response, compare against oldest prediction.
  initial begin
    choose_result_t want;
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (pending_choose.size() == 0) begin
        report_mismatch("unexpected response", rsp_ch.combinations, '0);
      end else begin
        want = pending_choose.pop_front();
        if (rsp_ch.combinations !== want.combinations)
          report_mismatch("combinations", rsp_ch.combinations, want.combinations);
        if (rsp_ch.bad_request !== want.bad_request)
          report_mismatch("bad_request", bcu_pkg::R_W'(rsp_ch.bad_request),
                          bcu_pkg::R_W'(want.bad_request));
      end
      @(negedge clk);
    end
  end

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_choose.size() != 0) @(negedge clk);
  endtask

  // Edges: zero pick, n == m, n > m, m above the limit, all-ones fields.
  task automatic test_directed();
    send_request(0, 0);
    send_request(1, 0);
    send_request(67, 0);
    send_request(67, 1);
    send_request(67, 33);
    send_request(67, 34);
    send_request(67, 67);
    send_request(66, 33);
    send_request(5, 5);
    send_request(5, 6);
    send_request(0, 1);
    send_request(68, 0);
    send_request(68, 3);
    send_request(127, 127);
    send_request(127, 0);
    send_request(10, 127);
    send_request(42, 21);
    send_request(1, 1);
    send_request(60, 30);
  endtask

  // Mostly valid requests with small n for runtime; a few large and invalid.
  task automatic test_random();
    int kind;
    logic [bcu_pkg::M_W-1:0] m, n;
    for (int i = 0; i < 120; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        m = bcu_pkg::M_W'($urandom_range(0, bcu_pkg::MAX_M));
        n = bcu_pkg::M_W'($urandom_range(0, (m < 8) ? m : 8));
      end else if (kind < 8) begin
        m = bcu_pkg::M_W'($urandom_range(0, bcu_pkg::MAX_M));
        n = bcu_pkg::M_W'($urandom_range(0, m));
      end else begin
        m = bcu_pkg::M_W'($urandom);
        n = bcu_pkg::M_W'($urandom);
      end
      send_request(m, n);
      if (i == 60) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_random();
    wait_drained();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("binomial_coefficient_unit_tb: clean");
    end else begin
      $display("binomial_coefficient_unit_tb: errors");
    end
    $finish;
  end

  // The worst case per request is far below this timeout.
  initial begin
    #200ms;
    $display("binomial_coefficient_unit_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bcu_pkg.sv
hdl/bcu_if.sv
hdl/bcu_div.sv
hdl/bcu_dp.sv
hdl/bcu_ctrl.sv
hdl/binomial_coefficient_unit.sv
tb/binomial_coefficient_unit_tb.sv
